// ===== sv/edcc_pkg.sv =====
package edcc_pkg;

  localparam int unsigned AluW = 32;

  typedef struct packed {
    logic        func;
    logic [31:0] timestamp;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } edcc_in_t;

  typedef struct packed {
    logic [15:0] day_count;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic        bad_input;
  } edcc_out_t;

  localparam logic FuncToDate  = 1'b0;
  localparam logic FuncToCount = 1'b1;

  localparam logic [AluW-1:0] DaySecs     = AluW'(86400);
  localparam logic [AluW-1:0] CycleDays   = AluW'(1461);
  localparam logic [AluW-1:0] TwoYearDays = AluW'(730);
  localparam logic [AluW-1:0] YearDays    = AluW'(365);
  localparam logic [AluW-1:0] EpochOffset = AluW'(671);
  localparam logic [11:0]     BaseYear    = 12'd1968;

  localparam int unsigned DayDivSteps = 16;
  localparam int unsigned CycDivSteps = 6;
  localparam logic [3:0]  LastMonth   = 4'd11;

  // 1461 * (1968 / 4) + 731 + 1, kept modulo 2^16 like the day count
  localparam logic [15:0] CountBias = 16'(1461 * 492 + 731 + 1);

  // month lengths starting from March, February last
  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] len;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10: len = 5'd31;
      4'd1, 4'd3, 4'd6, 4'd8:                    len = 5'd30;
      default:                                   len = 5'd29;
    endcase
    return len;
  endfunction

  // days before the first of a month, January is 1
  function automatic logic [8:0] month_start(input logic [3:0] mo);
    logic [8:0] start;
    case (mo)
      4'd1:    start = 9'd0;
      4'd2:    start = 9'd31;
      4'd3:    start = 9'd59;
      4'd4:    start = 9'd90;
      4'd5:    start = 9'd120;
      4'd6:    start = 9'd151;
      4'd7:    start = 9'd181;
      4'd8:    start = 9'd212;
      4'd9:    start = 9'd243;
      4'd10:   start = 9'd273;
      4'd11:   start = 9'd304;
      4'd12:   start = 9'd334;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

// ===== sv/edcc_sub.sv =====
module edcc_sub (
  input  logic [edcc_pkg::AluW-1:0] a_i,
  input  logic [edcc_pkg::AluW-1:0] b_i,
  output logic [edcc_pkg::AluW-1:0] diff_o,
  output logic                      ge_o
);

  logic [edcc_pkg::AluW:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[edcc_pkg::AluW-1:0];
  // no borrow means a >= b
  assign ge_o   = ~full[edcc_pkg::AluW];

endmodule

// ===== sv/epoch_day_calendar_converter_top.sv =====
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o | in_i  (edcc_in_t)
// out     | output    | out_valid_o/ out_ready_i | out_o (edcc_out_t)
//
// One item at a time; in_ready_o is high only while the sequencer is idle.
// Timestamp to date: day-divide steps, cycle-divide steps, a two-year step,
// a one-year step, month steps and a finish state; the divide, year and month
// steps all go through the one shared subtract-and-compare unit.
// Date to count: multiply, sum, finish; a flagged input skips to finish.
// The output register frees the sequencer; it stalls in finish only when the
// previous result is still untaken. Reset clears the sequencer and out_valid_o.
module epoch_day_calendar_converter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  edcc_pkg::edcc_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output edcc_pkg::edcc_out_t out_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DAYDIV = 9'b000000010,
    S_CYCDIV = 9'b000000100,
    S_TWOYR  = 9'b000001000,
    S_ONEYR  = 9'b000010000,
    S_MONTH  = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_SUM    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e                    state_q, state_d;
  logic                      out_valid_q, out_valid_d;
  edcc_pkg::edcc_out_t       out_q, out_d;
  edcc_pkg::edcc_in_t        in_q, in_d;
  logic [edcc_pkg::AluW-1:0] rem_q, rem_d;
  logic [15:0]               quo_q, quo_d;
  logic [11:0]               yr_q, yr_d;
  logic [3:0]                mo_q, mo_d;
  logic [3:0]                cnt_q, cnt_d;
  logic [15:0]               acc_q, acc_d;
  logic                      bad_q, bad_d;

  logic [edcc_pkg::AluW-1:0] sub_b;
  logic [edcc_pkg::AluW-1:0] sub_diff;
  logic                      sub_ge;
  logic                      in_bad;
  logic                      leap_add;
  logic [3:0]                mo_shift;
  logic                      yr_wrap;
  edcc_pkg::edcc_out_t       result;

  edcc_sub u_sub (
    .a_i    (rem_q),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  always_comb begin
    unique case (state_q)
      S_DAYDIV: sub_b = edcc_pkg::DaySecs << cnt_q;
      S_CYCDIV: sub_b = edcc_pkg::CycleDays << cnt_q;
      S_TWOYR:  sub_b = edcc_pkg::TwoYearDays;
      S_ONEYR:  sub_b = edcc_pkg::YearDays;
      S_MONTH:  sub_b = edcc_pkg::AluW'(edcc_pkg::month_len(mo_q));
      default:  sub_b = '0;
    endcase
  end

  assign in_bad   = (in_i.month == 4'd0) || (in_i.month > 4'd12) || (in_i.day == 5'd0);
  assign leap_add = (in_q.year[1:0] != 2'd0) || (in_q.month > 4'd2);

  // months were walked from March; fold back to January-based
  always_comb begin
    mo_shift = mo_q + 4'd2;
    yr_wrap  = 1'b0;
    if (mo_shift >= 4'd12) begin
      mo_shift = mo_shift - 4'd12;
      yr_wrap  = 1'b1;
    end
  end

  always_comb begin
    result = '0;
    if (bad_q) begin
      result.bad_input = 1'b1;
    end else if (in_q.func == edcc_pkg::FuncToCount) begin
      result.day_count = acc_q;
    end else begin
      result.day_count = quo_q;
      result.out_year  = yr_q + edcc_pkg::BaseYear + 12'(yr_wrap);
      result.out_month = mo_shift + 4'd1;
      result.out_day   = rem_q[4:0] + 5'd1;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    in_d        = in_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    yr_d        = yr_q;
    mo_d        = mo_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    bad_d       = bad_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d  = in_i;
          rem_d = in_i.timestamp;
          quo_d = '0;
          cnt_d = 4'(edcc_pkg::DayDivSteps - 1);
          if (in_i.func == edcc_pkg::FuncToDate) begin
            bad_d   = 1'b0;
            state_d = S_DAYDIV;
          end else begin
            bad_d   = in_bad;
            state_d = in_bad ? S_DONE : S_MUL;
          end
        end
      end
      S_DAYDIV: begin
        if (sub_ge) begin
          rem_d = sub_diff;
        end
        quo_d = {quo_q[14:0], sub_ge};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          // restart from 1 March 1968 with the full day count
          rem_d   = edcc_pkg::AluW'({quo_q[14:0], sub_ge}) + edcc_pkg::EpochOffset;
          yr_d    = '0;
          cnt_d   = 4'(edcc_pkg::CycDivSteps - 1);
          state_d = S_CYCDIV;
        end
      end
      S_CYCDIV: begin
        if (sub_ge) begin
          rem_d = sub_diff;
        end
        yr_d  = {yr_q[10:0], sub_ge};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          state_d = S_TWOYR;
        end
      end
      S_TWOYR: begin
        if (sub_ge) begin
          rem_d = sub_diff;
        end
        // four years per cycle, plus two when past the second year
        yr_d    = {yr_q[9:0], sub_ge, 1'b0};
        state_d = S_ONEYR;
      end
      S_ONEYR: begin
        if (sub_ge) begin
          rem_d = sub_diff;
        end
        yr_d    = yr_q + 12'(sub_ge);
        mo_d    = '0;
        state_d = S_MONTH;
      end
      S_MONTH: begin
        if (mo_q != edcc_pkg::LastMonth && sub_ge) begin
          rem_d = sub_diff;
          mo_d  = mo_q + 4'd1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL: begin
        acc_d   = {6'd0, in_q.year[11:2]} * 16'd1461;
        state_d = S_SUM;
      end
      S_SUM: begin
        acc_d   = acc_q + (16'(in_q.year[1:0]) * 16'd365) + 16'(leap_add)
                + 16'(edcc_pkg::month_start(in_q.month)) + 16'(in_q.day)
                - edcc_pkg::CountBias;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d       = result;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    in_q  <= in_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    yr_q  <= yr_d;
    mo_q  <= mo_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    bad_q <= bad_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("sequencer idle right after accepting an item");

  a_month_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MONTH) |-> (mo_q <= edcc_pkg::LastMonth))
    else $error("month walk ran past February");

  a_bad_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.bad_input) |-> (out_o.day_count == 16'd0))
    else $error("flagged result carries a day count");
`endif

endmodule
